// ----- rtl/brat_pkg.sv -----
// Package for the bus range address translator.
// Holds the command, result and window entry types, status codes and FSM states.
// No dependencies.
package brat_pkg;

	localparam int unsigned DATA_W = 32;

	localparam logic OP_TRANSLATE = 1'b0;
	localparam logic OP_LOAD      = 1'b1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOMATCH = 2'd1;
	localparam logic [1:0] ST_LOADED  = 2'd2;

	typedef struct packed {
		logic              opcode;
		logic [2:0]        entry_index;
		logic [DATA_W-1:0] child_space;
		logic [DATA_W-1:0] child_address;
		logic [DATA_W-1:0] request_size;
		logic [DATA_W-1:0] map_offset;
		logic [DATA_W-1:0] map_length;
		logic [DATA_W-1:0] parent_hi_in;
		logic [DATA_W-1:0] parent_mid_in;
		logic [DATA_W-1:0] parent_low_in;
		logic [DATA_W-1:0] window_size;
	} cmd_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [2:0]        matched_entry;
		logic [DATA_W-1:0] parent_hi;
		logic [DATA_W-1:0] parent_mid;
		logic [DATA_W-1:0] parent_low;
		logic [DATA_W-1:0] parent_size;
	} result_t;

	typedef struct packed {
		logic [DATA_W-1:0] space;
		logic [DATA_W-1:0] child_base;
		logic [DATA_W-1:0] parent_hi;
		logic [DATA_W-1:0] parent_mid;
		logic [DATA_W-1:0] parent_low;
		logic [DATA_W-1:0] size;
	} win_entry_t;

	typedef struct packed {
		logic              hit;
		logic [DATA_W-1:0] parent_low;
		logic [DATA_W-1:0] parent_size;
	} match_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_PREP,
		S_SCAN
	} state_t;

endpackage

// ----- rtl/brat_win_mem.sv -----
// Window table: single write port, single registered read port.
// Depends on brat_pkg for the entry type.
module brat_win_mem #(
	parameter int unsigned ENTRIES = 8,
	parameter int unsigned IDX_W   = 3
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [IDX_W-1:0]      wr_idx,
	input  brat_pkg::win_entry_t  wr_data,
	input  logic                  rd_en,
	input  logic [IDX_W-1:0]      rd_idx,
	output brat_pkg::win_entry_t  rd_data
);

	brat_pkg::win_entry_t mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_idx];
		end
	end

endmodule

// ----- rtl/brat_match.sv -----
// Containment check of one request region against one window entry.
// Depends on brat_pkg for the entry and match types.
module brat_match (
	input  brat_pkg::win_entry_t          entry,
	input  logic [brat_pkg::DATA_W-1:0]   space,
	input  logic [brat_pkg::DATA_W-1:0]   addr,
	input  logic [brat_pkg::DATA_W-1:0]   rsize,
	input  logic [brat_pkg::DATA_W-1:0]   last_req,
	output brat_pkg::match_t              match
);

	logic [brat_pkg::DATA_W-1:0] last_win;
	logic [brat_pkg::DATA_W-1:0] delta;
	logic [brat_pkg::DATA_W-1:0] left;

	always_comb begin
		last_win = entry.child_base + entry.size - brat_pkg::DATA_W'(1);
		delta    = addr - entry.child_base;
		left     = entry.size - delta;
		match.hit = (entry.space == space) && !(addr < entry.child_base) &&
			!(last_req > last_win);
		match.parent_low  = entry.parent_low + delta;
		match.parent_size = (rsize < left) ? rsize : left;
	end

endmodule

// ----- rtl/bus_range_address_translator.sv -----
// Bus range address translator: top level with command sequencer.
// Depends on brat_pkg, brat_win_mem and brat_match.
//
// Usage:
//   A command transfer takes place on a clock edge with start high and busy
//   low. A load command writes one window entry and its result (status
//   loaded) is strobed on done in the following cycle; busy stays low, so a
//   new command may follow at once.
//   A translate command scans the window table from entry zero, one entry
//   per cycle through the single read port of the table memory. busy is high
//   from the cycle after the transfer until the scan ends. Prep reads entry
//   zero; scan compares each entry read and reads the next until one matches
//   or the last active entry is examined. With an active count of zero the
//   result follows in the next cycle. The next command can be taken in the
//   cycle of the strobe. The result is valid for the single cycle in which
//   done is high; the receiver cannot stall it.
//   cfg_we/cfg_wdata set the active entry count; write it only while idle.
//   Reset clears the count and the sequencer; table contents are undefined
//   until loaded.
module bus_range_address_translator #(
	parameter int unsigned WINDOW_ENTRIES = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  brat_pkg::cmd_t    cmd,
	output logic              done,
	output brat_pkg::result_t result,
	input  logic              cfg_we,
	input  logic [3:0]        cfg_wdata
);

	localparam int unsigned IDX_W = (WINDOW_ENTRIES > 1) ? $clog2(WINDOW_ENTRIES) : 1;
	localparam int unsigned CNT_W = $clog2(WINDOW_ENTRIES + 1);

	brat_pkg::state_t state_q, state_d;

	logic [3:0]                  range_count_q;
	logic [CNT_W-1:0]            n_q, n_d;
	logic [IDX_W-1:0]            cmp_idx_q, cmp_idx_d;
	logic [brat_pkg::DATA_W-1:0] space_q, addr_q, rsize_q, last_req_q;
	logic                        done_q, done_d;
	brat_pkg::result_t           result_q, result_d;

	logic                        accept;
	logic                        wr_en, rd_en;
	logic [IDX_W-1:0]            rd_idx;
	brat_pkg::win_entry_t        wr_data, rd_data;
	brat_pkg::match_t            match;
	logic                        last_entry;

	assign accept = start && !busy;
	assign busy   = (state_q != brat_pkg::S_IDLE);
	assign done   = done_q;
	assign result = result_q;

	assign wr_data.space      = cmd.child_space;
	assign wr_data.child_base = cmd.child_address;
	assign wr_data.parent_hi  = cmd.parent_hi_in;
	assign wr_data.parent_mid = cmd.parent_mid_in;
	assign wr_data.parent_low = cmd.parent_low_in;
	assign wr_data.size       = cmd.window_size;

	assign wr_en = accept && (cmd.opcode == brat_pkg::OP_LOAD) &&
		(32'(cmd.entry_index) < WINDOW_ENTRIES);

	assign last_entry = ((32'(cmp_idx_q) + 32'd1) == 32'(n_q));

	brat_win_mem #(
		.ENTRIES (WINDOW_ENTRIES),
		.IDX_W   (IDX_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_idx  (IDX_W'(cmd.entry_index)),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_idx  (rd_idx),
		.rd_data (rd_data)
	);

	brat_match u_match (
		.entry    (rd_data),
		.space    (space_q),
		.addr     (addr_q),
		.rsize    (rsize_q),
		.last_req (last_req_q),
		.match    (match)
	);

	always_comb begin
		if (32'(range_count_q) > WINDOW_ENTRIES) begin
			n_d = CNT_W'(WINDOW_ENTRIES);
		end else begin
			n_d = CNT_W'(range_count_q);
		end
	end

	always_comb begin
		state_d   = state_q;
		cmp_idx_d = cmp_idx_q;
		done_d    = 1'b0;
		result_d  = '0;
		rd_en     = 1'b0;
		rd_idx    = '0;
		case (state_q)
			brat_pkg::S_IDLE: begin
				if (accept) begin
					if (cmd.opcode == brat_pkg::OP_LOAD) begin
						done_d          = 1'b1;
						result_d.status = brat_pkg::ST_LOADED;
					end else if (n_d == '0) begin
						done_d          = 1'b1;
						result_d.status = brat_pkg::ST_NOMATCH;
					end else begin
						state_d = brat_pkg::S_PREP;
					end
				end
			end
			brat_pkg::S_PREP: begin
				rd_en     = 1'b1;
				rd_idx    = '0;
				cmp_idx_d = '0;
				state_d   = brat_pkg::S_SCAN;
			end
			brat_pkg::S_SCAN: begin
				if (match.hit) begin
					done_d                 = 1'b1;
					result_d.status        = brat_pkg::ST_OK;
					result_d.matched_entry = 3'(32'(cmp_idx_q));
					result_d.parent_hi     = rd_data.parent_hi;
					result_d.parent_mid    = rd_data.parent_mid;
					result_d.parent_low    = match.parent_low;
					result_d.parent_size   = match.parent_size;
					state_d                = brat_pkg::S_IDLE;
				end else if (last_entry) begin
					done_d          = 1'b1;
					result_d.status = brat_pkg::ST_NOMATCH;
					state_d         = brat_pkg::S_IDLE;
				end else begin
					rd_en     = 1'b1;
					rd_idx    = cmp_idx_q + IDX_W'(1);
					cmp_idx_d = cmp_idx_q + IDX_W'(1);
				end
			end
			default: begin
				state_d = brat_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= brat_pkg::S_IDLE;
			done_q        <= 1'b0;
			range_count_q <= '0;
			cmp_idx_q     <= '0;
			n_q           <= '0;
		end else begin
			state_q   <= state_d;
			done_q    <= done_d;
			cmp_idx_q <= cmp_idx_d;
			if (cfg_we) begin
				range_count_q <= cfg_wdata;
			end
			if (accept) begin
				n_q <= n_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		result_q <= result_d;
		if (accept) begin
			space_q <= cmd.child_space;
			addr_q  <= cmd.child_address + cmd.map_offset;
			rsize_q <= (cmd.map_length != '0) ? cmd.map_length : cmd.request_size;
		end
		if (state_q == brat_pkg::S_PREP) begin
			last_req_q <= addr_q + rsize_q - brat_pkg::DATA_W'(1);
		end
	end

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == brat_pkg::S_SCAN) |-> (32'(cmp_idx_q) < 32'(n_q)))
		else $error("scan index beyond active count");

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != brat_pkg::S_IDLE) |-> (n_q != '0))
		else $error("scan started with no active entries");

	a_load_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status == brat_pkg::ST_LOADED)) |->
		$past(accept && (cmd.opcode == brat_pkg::OP_LOAD)))
		else $error("load result without load transfer");

	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q == brat_pkg::S_SCAN) || $past(accept)))
		else $error("result strobe without a command");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == brat_pkg::S_PREP) |-> $past(accept && (cmd.opcode == brat_pkg::OP_TRANSLATE)))
		else $error("scan entered without translate transfer");

endmodule

// ----- verif/bus_range_address_translator_tb.sv -----
// Testbench for bus_range_address_translator: window loads, translation and active count.
// Predicts each result from its own copy of the window table and compares field by field.
// Depends on brat_pkg and the RTL top level.
module bus_range_address_translator_tb;

	localparam int unsigned TABLE_DEPTH = 8;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam logic [31:0] SP_A = 32'h0000_00A5;
	localparam logic [31:0] SP_B = 32'h5A5A_0001;
	localparam logic [31:0] SP_C = 32'h8000_0000;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	brat_pkg::cmd_t       cmd;
	logic                 done;
	brat_pkg::result_t    result;
	logic                 cfg_we;
	logic [3:0]           cfg_wdata;

	brat_pkg::win_entry_t windows [TABLE_DEPTH];
	logic [3:0]           active_count;
	brat_pkg::result_t    expected_results [$];
	brat_pkg::result_t    oldest;
	logic [31:0]          space_pool [4];
	int unsigned          fail_count;
	int unsigned          cycle_count;
	bit                   no_gaps;

	bus_range_address_translator #(.WINDOW_ENTRIES(TABLE_DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding",
				cycle_count, expected_results.size());
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic report_fail(input string msg);
		$display("MISMATCH at cycle %0d: %s", cycle_count, msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_fail($sformatf("%s got %h expected %h", name, got, want));
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				report_fail("result with no transfer outstanding");
			end else begin
				oldest = expected_results.pop_front();
				check_field("status", 32'(result.status), 32'(oldest.status));
				check_field("matched_entry", 32'(result.matched_entry),
					32'(oldest.matched_entry));
				check_field("parent_hi", result.parent_hi, oldest.parent_hi);
				check_field("parent_mid", result.parent_mid, oldest.parent_mid);
				check_field("parent_low", result.parent_low, oldest.parent_low);
				check_field("parent_size", result.parent_size, oldest.parent_size);
			end
		end
	end

	// Updates the window copy on a load; first containing window wins on a translate.
	function automatic brat_pkg::result_t predict_result(input brat_pkg::cmd_t c);
		brat_pkg::result_t r;
		logic [31:0]       addr, rsize, last_req, last_win, delta, left;
		int unsigned       n;
		r = '0;
		if (c.opcode == brat_pkg::OP_LOAD) begin
			windows[c.entry_index] = '{space: c.child_space, child_base: c.child_address,
				parent_hi: c.parent_hi_in, parent_mid: c.parent_mid_in,
				parent_low: c.parent_low_in, size: c.window_size};
			r.status = brat_pkg::ST_LOADED;
			return r;
		end
		addr = c.child_address + c.map_offset;
		rsize = (c.map_length != '0) ? c.map_length : c.request_size;
		n = (active_count > TABLE_DEPTH) ? TABLE_DEPTH : active_count;
		for (int i = 0; i < n; i++) begin
			if (windows[i].space != c.child_space)
				continue;
			last_req = addr + rsize - 32'd1;
			last_win = windows[i].child_base + windows[i].size - 32'd1;
			if (addr < windows[i].child_base || last_req > last_win)
				continue;
			delta = addr - windows[i].child_base;
			left = windows[i].size - delta;
			r.status = brat_pkg::ST_OK;
			r.matched_entry = i[2:0];
			r.parent_hi = windows[i].parent_hi;
			r.parent_mid = windows[i].parent_mid;
			r.parent_low = windows[i].parent_low + delta;
			r.parent_size = (rsize < left) ? rsize : left;
			return r;
		end
		r.status = brat_pkg::ST_NOMATCH;
		return r;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (no_gaps || pick < 50)
			return 0;
		else if (pick < 85)
			return $urandom_range(1, 3);
		else if (pick < 97)
			return $urandom_range(4, 9);
		return $urandom_range(10, 40);
	endfunction

	function automatic brat_pkg::cmd_t random_cmd();
		brat_pkg::cmd_t c;
		logic [351:0]   bits;
		bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom};
		c = bits[$bits(brat_pkg::cmd_t)-1:0];
		return c;
	endfunction

	// Called just after a falling edge; returns just after the falling edge that
	// follows the transfer. start stays high when the next command comes at once.
	task automatic send_cmd(input brat_pkg::cmd_t c);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		do
			@(posedge clk);
		while (busy);
		expected_results.push_back(predict_result(c));
		@(negedge clk);
	endtask

	task automatic set_range_count(input logic [3:0] value);
		start <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		active_count = value;
	endtask

	task automatic load_window(input logic [2:0] idx, input logic [31:0] space,
			input logic [31:0] base, input logic [31:0] size, input logic [31:0] phi,
			input logic [31:0] pmid, input logic [31:0] plow);
		brat_pkg::cmd_t c;
		c = random_cmd();
		c.opcode = brat_pkg::OP_LOAD;
		c.entry_index = idx;
		c.child_space = space;
		c.child_address = base;
		c.window_size = size;
		c.parent_hi_in = phi;
		c.parent_mid_in = pmid;
		c.parent_low_in = plow;
		send_cmd(c);
	endtask

	task automatic translate(input logic [31:0] space, input logic [31:0] addr,
			input logic [31:0] size, input logic [31:0] offset, input logic [31:0] length);
		brat_pkg::cmd_t c;
		c = random_cmd();
		c.opcode = brat_pkg::OP_TRANSLATE;
		c.child_space = space;
		c.child_address = addr;
		c.request_size = size;
		c.map_offset = offset;
		c.map_length = length;
		send_cmd(c);
	endtask

	function automatic brat_pkg::cmd_t make_window_load();
		brat_pkg::cmd_t c;
		int unsigned    pick;
		c = random_cmd();
		c.opcode = brat_pkg::OP_LOAD;
		c.child_space = space_pool[$urandom_range(0, 3)];
		pick = $urandom_range(0, 99);
		if (pick < 50)
			c.window_size = $urandom_range(1, 4096);
		else if (pick < 75)
			c.window_size = $urandom_range(1, 32'h00FF_FFFF);
		else if (pick < 85)
			c.window_size = $urandom;
		else if (pick < 92)
			c.window_size = '1;
		else
			c.window_size = '0;
		if ($urandom_range(0, 9) == 0)
			c.child_address = 32'hFFFF_FFFF - $urandom_range(0, 8191);
		return c;
	endfunction

	// Aims at a loaded window: mostly inside it, sometimes just past its end,
	// below its base or in the wrong space.
	function automatic brat_pkg::cmd_t make_hit_translate();
		brat_pkg::cmd_t       c;
		brat_pkg::win_entry_t w;
		logic [31:0]          delta, room, len;
		int unsigned          pick, top;
		c = random_cmd();
		c.opcode = brat_pkg::OP_TRANSLATE;
		top = (active_count == 0) ? TABLE_DEPTH - 1
			: ((active_count > TABLE_DEPTH) ? TABLE_DEPTH - 1 : active_count - 1);
		w = windows[$urandom_range(0, top)];
		c.child_space = w.space;
		delta = '0;
		len = '0;
		if (w.size != '0) begin
			delta = $urandom_range(0, w.size - 32'd1);
			room = w.size - delta;
			pick = $urandom_range(0, 99);
			if (pick < 20)
				len = room;
			else if (pick < 30)
				len = room + 32'd1;
			else if (pick < 35) begin
				delta = '1;
				len = 32'd1;
			end else if (pick < 40) begin
				len = $urandom_range(1, room);
				c.child_space = c.child_space ^ 32'd1;
			end else if (pick < 45)
				len = '0;
			else
				len = $urandom_range(1, room);
		end
		if (len == '0 || $urandom_range(0, 1) == 0) begin
			c.map_length = '0;
			c.request_size = len;
		end else begin
			c.map_length = len;
		end
		if ($urandom_range(0, 1) == 0)
			c.map_offset = '0;
		c.child_address = w.child_base + delta - c.map_offset;
		return c;
	endfunction

	task automatic test_empty_table();
		brat_pkg::cmd_t c;
		c = '0;
		send_cmd(c);
		c = '1;
		c.opcode = brat_pkg::OP_TRANSLATE;
		send_cmd(c);
	endtask

	task automatic test_window_loads();
		load_window(3'd0, SP_A, 32'h0000_1000, 32'h0000_1000, 32'h1111_0000,
			32'h2222_0000, 32'h4000_0000);
		load_window(3'd1, SP_A, 32'h0000_1800, 32'h0000_2000, 32'h1111_0001,
			32'h2222_0001, 32'h5000_0000);
		load_window(3'd2, SP_B, 32'hFFFF_F000, 32'h0000_1000, 32'h1111_0002,
			32'h2222_0002, 32'hFFFF_FF00);
		load_window(3'd3, SP_B, 32'hFFFF_F000, 32'h0000_2000, 32'h1111_0003,
			32'h2222_0003, 32'h6000_0000);
		load_window(3'd4, '0, '0, '0, '0, '0, '0);
		load_window(3'd5, '1, '1, '1, '1, '1, '1);
		load_window(3'd6, SP_C, 32'h8000_0000, 32'h0000_0100, 32'h1111_0006,
			32'h2222_0006, 32'h7000_0000);
		load_window(3'd7, SP_A, '0, '1, 32'h1111_0007, 32'h2222_0007, 32'h0000_0010);
	endtask

	// Region straddles the end of entry 0 and fits entry 1.
	task automatic test_count_extremes();
		set_range_count(4'd1);
		translate(SP_A, 32'h0000_1F00, 32'h0000_0200, '0, '0);
		set_range_count(4'd15);
		translate(SP_A, 32'h0000_1F00, 32'h0000_0200, '0, '0);
		set_range_count(4'd9);
		translate(SP_A, 32'h0000_1F00, 32'h0000_0200, '0, '0);
	endtask

	task automatic test_region_edges();
		set_range_count(4'd8);
		translate(SP_A, 32'h0000_1000, 32'h0000_1000, '0, '0);
		translate(SP_A, 32'h0000_1000, 32'h0000_1001, '0, '0);
		translate(SP_A, 32'h0000_0FFF, 32'h0000_0001, '0, '0);
		translate(SP_A, 32'hFFFF_F800, 32'h0000_DEAD, 32'h0000_1800, 32'h0000_0020);
		translate(SP_B, 32'hFFFF_FFF0, 32'h0000_0010, '0, '0);
		translate(SP_B, 32'hFFFF_FFF0, 32'h0000_0020, '0, '0);
		translate(SP_A, 32'h0000_1000, '0, '0, '0);
		translate('0, '0, '0, '0, '0);
		translate('1, '1, 32'h0000_0001, '0, '0);
		translate(SP_C, 32'h8000_00FF, 32'h0000_0001, '0, '0);
		translate(SP_C, 32'h8000_00FF, 32'h0000_0002, '0, '0);
		translate(32'h0BAD_5ACE, 32'h0000_1000, 32'h0000_0010, '0, '0);
	endtask

	task automatic test_random_traffic();
		logic [3:0]     phase_counts [12];
		brat_pkg::cmd_t c;
		int unsigned    pick;
		phase_counts = '{4'd8, 4'd15, 4'd9, 4'd1, 4'd0, 4'd3, 4'd8, 4'd5, 4'd12, 4'd8,
			4'd2, 4'd7};
		space_pool = '{'0, '1, $urandom, $urandom};
		for (int phase = 0; phase < 12; phase++) begin
			set_range_count(phase_counts[phase]);
			no_gaps = (phase % 4 == 3);
			for (int i = 0; i < 125; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 12) begin
					c = make_window_load();
				end else if (pick < 82) begin
					c = make_hit_translate();
				end else begin
					c = random_cmd();
					c.opcode = brat_pkg::OP_TRANSLATE;
					if (pick < 90)
						c.child_space = space_pool[$urandom_range(0, 3)];
				end
				send_cmd(c);
			end
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		active_count = '0;
		fail_count = 0;
		cycle_count = 0;
		no_gaps = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_table();
		test_window_loads();
		test_count_extremes();
		test_region_edges();
		test_random_traffic();

		start <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (expected_results.size() != 0)
			report_fail("results still outstanding at end of run");
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
